### src/cfp_pkg.sv
`timescale 1ns / 1ps
package cfp_pkg;

    localparam int POS_W    = 32;
    localparam int ACC_W    = 64;
    localparam int OUT_W    = 48;
    localparam int CHG_W    = 16;
    localparam int LEN_W    = 31;
    localparam int ADDR_W   = 5;
    localparam int CFAC_Q16 = 36748749;

    localparam logic [2:0] REG_PROBE_X = 3'd0;
    localparam logic [2:0] REG_PROBE_Y = 3'd1;
    localparam logic [2:0] REG_PROBE_Z = 3'd2;
    localparam logic [2:0] REG_AXIS_X  = 3'd3;
    localparam logic [2:0] REG_AXIS_Y  = 3'd4;
    localparam logic [2:0] REG_AXIS_Z  = 3'd5;
    localparam logic [2:0] REG_AXIS_L  = 3'd6;

    typedef struct packed {
        logic signed [POS_W-1:0] atom_x;
        logic signed [POS_W-1:0] atom_y;
        logic signed [POS_W-1:0] atom_z;
        logic signed [CHG_W-1:0] atom_charge;
        logic                    first_atom;
        logic                    last_atom;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] projected_field;
        logic                    zero_distance_seen;
        logic                    saturated;
    } t_out_item;

    typedef struct packed {
        logic signed [POS_W-1:0] probe_x;
        logic signed [POS_W-1:0] probe_y;
        logic signed [POS_W-1:0] probe_z;
        logic signed [POS_W-1:0] axis_x;
        logic signed [POS_W-1:0] axis_y;
        logic signed [POS_W-1:0] axis_z;
        logic [LEN_W-1:0]        axis_length;
    } t_cfg;

    typedef enum logic [12:0] {
        ST_IDLE  = 13'b0000000000001,
        ST_NORM  = 13'b0000000000010,
        ST_SQ    = 13'b0000000000100,
        ST_SQRT  = 13'b0000000001000,
        ST_DEN   = 13'b0000000010000,
        ST_NUM   = 13'b0000000100000,
        ST_DIV   = 13'b0000001000000,
        ST_ACC   = 13'b0000010000000,
        ST_PROJ  = 13'b0000100000000,
        ST_MULC  = 13'b0001000000000,
        ST_PDIV  = 13'b0010000000000,
        ST_ROUND = 13'b0100000000000,
        ST_OUT   = 13'b1000000000000
    } t_state;

endpackage

### src/cfp_regs.sv
`timescale 1ns / 1ps
module cfp_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfp_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output cfp_pkg::t_cfg               o_cfg
);
    import cfp_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.probe_x     <= '0;
            r_cfg.probe_y     <= '0;
            r_cfg.probe_z     <= '0;
            r_cfg.axis_x      <= 32'sd65536;
            r_cfg.axis_y      <= '0;
            r_cfg.axis_z      <= '0;
            r_cfg.axis_length <= 31'd65536;
        end else if (wr) begin
            case (idx)
                REG_PROBE_X: r_cfg.probe_x     <= pwdata;
                REG_PROBE_Y: r_cfg.probe_y     <= pwdata;
                REG_PROBE_Z: r_cfg.probe_z     <= pwdata;
                REG_AXIS_X:  r_cfg.axis_x      <= pwdata;
                REG_AXIS_Y:  r_cfg.axis_y      <= pwdata;
                REG_AXIS_Z:  r_cfg.axis_z      <= pwdata;
                REG_AXIS_L:  r_cfg.axis_length <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PROBE_X: prdata = r_cfg.probe_x;
            REG_PROBE_Y: prdata = r_cfg.probe_y;
            REG_PROBE_Z: prdata = r_cfg.probe_z;
            REG_AXIS_X:  prdata = r_cfg.axis_x;
            REG_AXIS_Y:  prdata = r_cfg.axis_y;
            REG_AXIS_Z:  prdata = r_cfg.axis_z;
            REG_AXIS_L:  prdata = {1'b0, r_cfg.axis_length};
            default:     prdata = '0;
        endcase
    end
endmodule

### src/cfp_mul.sv
`timescale 1ns / 1ps
module cfp_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);
    logic signed [65:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

### src/cfp_csub.sv
`timescale 1ns / 1ps
module cfp_csub (
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_diff,
    output logic        o_ge
);
    logic [64:0] d;

    assign d      = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = !d[64];
    assign o_diff = d[63:0];
endmodule

### src/cfp_core.sv
`timescale 1ns / 1ps
module cfp_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cfp_pkg::t_cfg        i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cfp_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cfp_pkg::t_out_item   o_out_data
);
    import cfp_pkg::*;

    t_state             r_state, n_state;
    logic [35:0]        r_mag [3];
    logic [35:0]        n_mag [3];
    logic [2:0]         r_dneg, n_dneg;
    logic               r_qneg, n_qneg;
    logic [15:0]        r_qmag, n_qmag;
    logic               r_last, n_last;
    logic signed [63:0] r_acc [3];
    logic signed [63:0] n_acc [3];
    logic               r_zero, n_zero;
    logic               r_sat, n_sat;
    logic signed [5:0]  r_s, n_s;
    logic [6:0]         r_cnt, n_cnt;
    logic [1:0]         r_comp, n_comp;
    logic [41:0]        r_r2, n_r2;
    logic [30:0]        r_rt, n_rt;
    logic [63:0]        r_rem, n_rem;
    logic [61:0]        r_v, n_v;
    logic [62:0]        r_den, n_den;
    logic [63:0]        r_quo, n_quo;
    logic signed [97:0] r_sum, n_sum;
    logic [127:0]       r_wide, n_wide;
    logic               r_neg, n_neg;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [63:0]        cs_a, cs_b, cs_diff;
    logic               cs_ge;

    logic signed [32:0] pdiff [3];
    logic signed [36:0] dten [3];
    logic signed [POS_W-1:0] probe_arr [3];
    logic signed [POS_W-1:0] atom_arr [3];
    logic signed [POS_W-1:0] axis_arr [3];
    logic [35:0]        mmax;
    logic signed [7:0]  k_s;
    logic [6:0]         k;
    logic [54:0]        dv;
    logic [LEN_W-1:0]   len;
    logic [34:0]        sq_rs;
    logic [32:0]        sq_trial;
    logic [63:0]        dv_shift;
    logic [55:0]        pd_rs;
    logic [6:0]         cnt_m1;
    logic signed [64:0] acc_sum;
    logic signed [63:0] contrib;
    logic signed [63:0] acc_cur;
    logic signed [97:0] term;
    logic [31:0]        piece;
    logic [127:0]       wterm;
    logic               accept, out_free, clip;
    logic [127:0]       qv;

    localparam logic signed [64:0] ACC_MAX = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] ACC_MIN = -65'sh0_7FFF_FFFF_FFFF_FFFF - 65'sd1;

    cfp_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(mul_p));
    cfp_csub u_csub (.i_a(cs_a), .i_b(cs_b), .o_diff(cs_diff), .o_ge(cs_ge));

    assign probe_arr[0] = i_cfg.probe_x;
    assign probe_arr[1] = i_cfg.probe_y;
    assign probe_arr[2] = i_cfg.probe_z;
    assign atom_arr[0]  = i_in_data.atom_x;
    assign atom_arr[1]  = i_in_data.atom_y;
    assign atom_arr[2]  = i_in_data.atom_z;
    assign axis_arr[0]  = i_cfg.axis_x;
    assign axis_arr[1]  = i_cfg.axis_y;
    assign axis_arr[2]  = i_cfg.axis_z;

    assign accept      = (r_state == ST_IDLE) && i_in_valid;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pdiff[i] = 33'(probe_arr[i]) - 33'(atom_arr[i]);
            dten[i]  = (37'(pdiff[i]) <<< 3) + (37'(pdiff[i]) <<< 1);
        end
    end

    assign mmax = (r_mag[0] >= r_mag[1]) ?
                  ((r_mag[0] >= r_mag[2]) ? r_mag[0] : r_mag[2]) :
                  ((r_mag[1] >= r_mag[2]) ? r_mag[1] : r_mag[2]);

    assign k_s      = 8'sd52 - ({{2{r_s[5]}}, r_s} <<< 1);
    assign k        = k_s[6:0];
    assign len      = (i_cfg.axis_length == '0) ? LEN_W'(1) : i_cfg.axis_length;
    assign dv       = {len, 24'b0};
    assign sq_rs    = {r_rem[32:0], r_v[61:60]};
    assign sq_trial = {r_rt, 2'b01};
    assign dv_shift = {r_rem[62:0], 1'b0};
    assign pd_rs    = {r_rem[54:0], r_wide[127]};
    assign cnt_m1   = r_cnt - 7'd1;
    assign acc_cur  = r_acc[r_comp];
    assign contrib  = (r_qneg ^ r_dneg[r_comp]) ? -$signed(r_quo) : $signed(r_quo);
    assign acc_sum  = 65'(acc_cur) + 65'(contrib);
    assign qv       = r_wide;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        piece = '0;
        unique case (r_state)
            ST_SQ: begin
                mul_a = {13'b0, r_mag[r_cnt[1:0]][19:0]};
                mul_b = {13'b0, r_mag[r_cnt[1:0]][19:0]};
            end
            ST_DEN: begin
                mul_a = {1'b0, r_r2[41:10]};
                mul_b = {2'b0, r_rt};
            end
            ST_NUM: begin
                mul_a = {17'b0, r_qmag};
                mul_b = {13'b0, r_mag[r_comp][19:0]};
            end
            ST_PROJ: begin
                mul_a = r_cnt[0] ? 33'($signed(r_acc[r_cnt[2:1]][63:32]))
                                 : {1'b0, r_acc[r_cnt[2:1]][31:0]};
                mul_b = 33'(axis_arr[r_cnt[2:1]]);
            end
            ST_MULC: begin
                unique case (r_cnt[1:0])
                    2'd0: piece = r_sum[31:0];
                    2'd1: piece = r_sum[63:32];
                    2'd2: piece = r_sum[95:64];
                    2'd3: piece = {30'b0, r_sum[97:96]};
                endcase
                mul_a = {1'b0, piece};
                mul_b = 33'(CFAC_Q16);
            end
            default: ;
        endcase
    end

    always_comb begin
        cs_a = '0;
        cs_b = '0;
        unique case (r_state)
            ST_SQRT: begin
                cs_a = 64'(sq_rs);
                cs_b = 64'(sq_trial);
            end
            ST_DIV: begin
                cs_a = dv_shift;
                cs_b = 64'(r_den);
            end
            ST_PDIV: begin
                cs_a = 64'(pd_rs);
                cs_b = 64'(dv);
            end
            ST_ROUND: begin
                cs_a = {r_rem[62:0], 1'b0};
                cs_b = 64'(dv);
            end
            default: ;
        endcase
    end

    always_comb begin
        term  = '0;
        wterm = '0;
        clip  = 1'b0;
        n_state = r_state;
        n_mag = r_mag;
        n_dneg = r_dneg;
        n_qneg = r_qneg;
        n_qmag = r_qmag;
        n_last = r_last;
        n_acc = r_acc;
        n_zero = r_zero;
        n_sat = r_sat;
        n_s = r_s;
        n_cnt = r_cnt;
        n_comp = r_comp;
        n_r2 = r_r2;
        n_rt = r_rt;
        n_rem = r_rem;
        n_v = r_v;
        n_den = r_den;
        n_quo = r_quo;
        n_sum = r_sum;
        n_wide = r_wide;
        n_neg = r_neg;
        n_out = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    for (int i = 0; i < 3; i++) begin
                        n_dneg[i] = dten[i][36];
                        n_mag[i]  = dten[i][36] ? 36'(-dten[i]) : dten[i][35:0];
                    end
                    n_qneg = i_in_data.atom_charge[15];
                    n_qmag = i_in_data.atom_charge[15] ? 16'(-i_in_data.atom_charge)
                                                       : i_in_data.atom_charge;
                    n_last = i_in_data.last_atom;
                    n_s = '0;
                    if (i_in_data.first_atom) begin
                        for (int i = 0; i < 3; i++) n_acc[i] = '0;
                        n_zero = 1'b0;
                        n_sat = 1'b0;
                    end
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                if (mmax == '0) begin
                    n_zero = 1'b1;
                    n_cnt = '0;
                    n_sum = '0;
                    n_state = r_last ? ST_PROJ : ST_IDLE;
                end else if (mmax >= 36'(1 << 20)) begin
                    for (int i = 0; i < 3; i++) n_mag[i] = r_mag[i] >> 1;
                    n_s = r_s + 6'sd1;
                end else if (mmax < 36'(1 << 19)) begin
                    for (int i = 0; i < 3; i++) n_mag[i] = r_mag[i] << 1;
                    n_s = r_s - 6'sd1;
                end else begin
                    n_cnt = '0;
                    n_r2 = '0;
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                if (r_cnt != '0) n_r2 = r_r2 + mul_p[41:0];
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd3) begin
                    n_v = {n_r2, 20'b0};
                    n_rem = '0;
                    n_rt = '0;
                    n_cnt = '0;
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (cs_ge) begin
                    n_rem = 64'(cs_diff[32:0]);
                    n_rt = {r_rt[29:0], 1'b1};
                end else begin
                    n_rem = 64'(sq_rs[32:0]);
                    n_rt = {r_rt[29:0], 1'b0};
                end
                n_v = {r_v[59:0], 2'b0};
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd30) begin
                    n_cnt = '0;
                    n_state = ST_DEN;
                end
            end
            ST_DEN: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt != '0) begin
                    n_den = mul_p[62:0];
                    n_cnt = '0;
                    n_comp = '0;
                    n_state = ST_NUM;
                end
            end
            ST_NUM: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt != '0) begin
                    n_rem = 64'(mul_p[35:0]);
                    n_quo = '0;
                    n_cnt = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (cs_ge) begin
                    n_rem = cs_diff;
                    n_quo = {r_quo[62:0], 1'b1};
                end else begin
                    n_rem = dv_shift;
                    n_quo = {r_quo[62:0], 1'b0};
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == k - 7'd1) n_state = ST_ACC;
            end
            ST_ACC: begin
                if (acc_sum > ACC_MAX) begin
                    n_acc[r_comp] = 64'(ACC_MAX);
                    n_sat = 1'b1;
                end else if (acc_sum < ACC_MIN) begin
                    n_acc[r_comp] = 64'(ACC_MIN);
                    n_sat = 1'b1;
                end else begin
                    n_acc[r_comp] = acc_sum[63:0];
                end
                n_cnt = '0;
                if (r_comp == 2'd2) begin
                    n_sum = '0;
                    n_state = r_last ? ST_PROJ : ST_IDLE;
                end else begin
                    n_comp = r_comp + 2'd1;
                    n_state = ST_NUM;
                end
            end
            ST_PROJ: begin
                if (r_cnt != '0) begin
                    term = r_cnt[0] ? 98'(mul_p) : (98'(mul_p) <<< 32);
                    n_sum = r_sum + term;
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd6) begin
                    n_neg = n_sum[97];
                    n_sum = n_sum[97] ? -n_sum : n_sum;
                    n_wide = '0;
                    n_cnt = '0;
                    n_state = ST_MULC;
                end
            end
            ST_MULC: begin
                if (r_cnt != '0) begin
                    wterm = 128'(mul_p[57:0]) << {cnt_m1[1:0], 5'b0};
                    n_wide = r_wide + wterm;
                end
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd4) begin
                    n_rem = '0;
                    n_cnt = '0;
                    n_state = ST_PDIV;
                end
            end
            ST_PDIV: begin
                n_rem = cs_ge ? 64'(cs_diff[54:0]) : 64'(pd_rs[54:0]);
                n_wide = {r_wide[126:0], cs_ge};
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'd127) n_state = ST_ROUND;
            end
            ST_ROUND: begin
                n_wide = r_wide + 128'(cs_ge);
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    if (r_neg) begin
                        clip = (qv[127:48] != '0) || (qv[47] && (qv[46:0] != '0));
                        n_out.projected_field = clip ? {1'b1, 47'b0} : -qv[47:0];
                    end else begin
                        clip = (qv[127:47] != '0);
                        n_out.projected_field = clip ? {1'b0, {47{1'b1}}} : qv[47:0];
                    end
                    n_out.zero_distance_seen = r_zero;
                    n_out.saturated = r_sat || clip;
                    n_out_valid = 1'b1;
                    for (int i = 0; i < 3; i++) n_acc[i] = '0;
                    n_zero = 1'b0;
                    n_sat = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) r_acc[i] <= '0;
            r_zero <= 1'b0;
            r_sat <= 1'b0;
            r_cnt <= '0;
            r_comp <= '0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            r_acc <= n_acc;
            r_zero <= n_zero;
            r_sat <= n_sat;
            r_cnt <= n_cnt;
            r_comp <= n_comp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_dneg <= n_dneg;
        r_qneg <= n_qneg;
        r_qmag <= n_qmag;
        r_last <= n_last;
        r_s <= n_s;
        r_r2 <= n_r2;
        r_rt <= n_rt;
        r_rem <= n_rem;
        r_v <= n_v;
        r_den <= n_den;
        r_quo <= n_quo;
        r_sum <= n_sum;
        r_wide <= n_wide;
        r_neg <= n_neg;
        r_out <= n_out;
    end
endmodule

### src/coulomb_field_projection.sv
`timescale 1ns / 1ps
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_stall   i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_stall o_out_data (t_out_item)
// config    input      psel penable pwrite pready paddr pwdata prdata
//
// one atom passes in order through normalize, square, square-root steps and denominator,
// then numerator, divider steps and accumulate for each component, all on the shared
// multiplier and subtractor; an atom on the probe point stops after normalize;
// the last atom of a run adds projection and scale products, divider steps, round, output
// synchronous active-low reset clears the run state and the output valid flag
// a result waits in the output register under stall while new atoms are taken
module coulomb_field_projection (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  cfp_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output cfp_pkg::t_out_item          o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfp_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import cfp_pkg::*;

    t_cfg cfg;

    cfp_regs u_regs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_cfg(cfg)
    );

    cfp_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data)
    );
endmodule

### src/cfp_checker.sv
`timescale 1ns / 1ps
module cfp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input cfp_pkg::t_out_item o_out_data
);
    import cfp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("ready right after a request");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without work in progress");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset left block busy");
endmodule

bind coulomb_field_projection cfp_checker u_cfp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_stall(o_in_stall), .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall), .o_out_data(o_out_data)
);
